// ===== rtl/core/max_normalized_sqrt_quantizer_macros.svh =====
`ifndef MAX_NORMALIZED_SQRT_QUANTIZER_MACROS_SVH
`define MAX_NORMALIZED_SQRT_QUANTIZER_MACROS_SVH

// Condition and consequence in the same cycle.
`define MNSQ_ASSERT_SAME(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle, consequence in the next.
`define MNSQ_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mnsq_pkg.sv =====
package mnsq_pkg;

    // Sample width; samples are unsigned fixed point with 16 fraction bits at 24.
    localparam int SAMPLE_WIDTH = 24;

    // Dividend 2*25499*r + 100*p and divisor 200*p widths.
    localparam int NUM_W = SAMPLE_WIDTH + 17;
    localparam int DEN_W = SAMPLE_WIDTH + 8;

    // Result accumulator holds a root or a 9-bit quotient.
    localparam int ACC_W = (SAMPLE_WIDTH > 9) ? SAMPLE_WIDTH : 9;
    localparam int CNT_W = $clog2(ACC_W);

    // Quotient bits per division: bit 8 flags saturation.
    localparam int DIV_STEPS = 9;

    // Scale 254.99 = 25499/100 with round half up.
    localparam int SCALE_NUM2     = 50998;
    localparam int SCALE_HALF_DEN = 100;
    localparam int SCALE_DEN2     = 200;
    localparam logic [7:0] OUT_MAX = 8'hFF;

    // Stream payload widths.
    localparam int IN_DATA_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = 24;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_DARK_THRESHOLD = 3'd0;

    // Item kinds.
    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    typedef enum logic
    {
        OP_ROOT,
        OP_DIV
    } unit_op_t;

    // Command to the shared root/divide unit.
    typedef struct packed
    {
        logic             start;
        unit_op_t         op;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } unit_cmd_t;

    // Response from the shared unit.
    typedef struct packed
    {
        logic             done;
        logic [ACC_W-1:0] value;
    } unit_rsp_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ROOT_P,
        ST_WAIT_P,
        ST_ROOT_C,
        ST_WAIT_C,
        ST_SCALE,
        ST_DIV,
        ST_WAIT_D,
        ST_NEXT,
        ST_OUT
    } seq_state_t;

endpackage

// ===== rtl/core/mnsq_unit.sv =====
module mnsq_unit
    import mnsq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_cmd_t cmd,
    output unit_rsp_t rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    unit_op_t                    op_reg, op_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [NUM_W-1:0]            rem_reg, rem_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [2*SAMPLE_WIDTH-1:0]   rad_reg, rad_next;
    logic [NUM_W-1:0]            dsh_reg, dsh_next;

    logic [NUM_W-1:0] root_a;
    logic [NUM_W-1:0] root_b;
    logic [NUM_W-1:0] op_a;
    logic [NUM_W-1:0] op_b;
    logic [NUM_W-1:0] diff;
    logic             ge;

    // Root step: bring down two radicand bits and try 4*root + 1.
    assign root_a = NUM_W'({rem_reg[SAMPLE_WIDTH:0], rad_reg[2*SAMPLE_WIDTH-1 -: 2]});
    assign root_b = NUM_W'({acc_reg[SAMPLE_WIDTH-1:0], 2'b01});

    // The one shared compare and subtract.
    always_comb
    begin
        unique case (op_reg)
            OP_ROOT:
            begin
                op_a = root_a;
                op_b = root_b;
            end
            OP_DIV:
            begin
                op_a = rem_reg;
                op_b = dsh_reg;
            end
            default:
            begin
                op_a = rem_reg;
                op_b = dsh_reg;
            end
        endcase
    end

    assign ge   = (op_a >= op_b);
    assign diff = op_a - op_b;

    // Load on a command, otherwise take one restoring step per cycle while busy.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        rad_next  = rad_reg;
        dsh_next  = dsh_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            acc_next  = '0;
            if (cmd.op == OP_ROOT)
            begin
                rem_next = '0;
                rad_next = {cmd.num[SAMPLE_WIDTH-1:0], {SAMPLE_WIDTH{1'b0}}};
                cnt_next = CNT_W'(SAMPLE_WIDTH - 1);
            end
            else
            begin
                rem_next = cmd.num;
                dsh_next = NUM_W'(cmd.den) << 8;
                cnt_next = CNT_W'(DIV_STEPS - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : op_a;
            acc_next = {acc_reg[ACC_W-2:0], ge};
            rad_next = rad_reg << 2;
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        rad_reg <= rad_next;
        dsh_reg <= dsh_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

// ===== rtl/core/max_normalized_sqrt_quantizer.sv =====
// Peak-normalized square-root quantizer. The host streams a frame twice: measure items
// (tuser bit 0 low) update a running peak over all three channels, restarted by tuser
// bit 1, and give no result; convert items (tuser bit 0 high) give one result per pixel,
// each channel round(254.99 * sqrt(c) / sqrt(peak)) saturated at 255, or zeros with the
// too-dark flag when the peak lies below dark_threshold (APB address 0, reset 1).
// A measure item leaves the block ready for the next item. A convert item uses one shared
// restoring unit, which computes a 24-step root and a 9-step division for each channel in
// turn, and the peak root once for the first convert after a measure pass. A too-dark
// item skips the unit. The block accepts no item while one is in work.
module max_normalized_sqrt_quantizer
    import mnsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]            s_axis_tuser,   // kind, frame_start
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic [0:0]            m_axis_tuser,   // too_dark
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    seq_state_t state_reg, state_next;

    logic [SAMPLE_WIDTH-1:0] thr_reg, thr_next;
    logic [SAMPLE_WIDTH-1:0] peak_value_reg, peak_value_next;
    logic [SAMPLE_WIDTH-1:0] peak_root_reg, peak_root_next;
    logic                    root_ready_reg, root_ready_next;
    logic [SAMPLE_WIDTH-1:0] samp_reg [3];
    logic [SAMPLE_WIDTH-1:0] samp_next [3];
    logic [7:0]              q_reg [3];
    logic [7:0]              q_next [3];
    logic [1:0]              ch_reg, ch_next;
    logic [SAMPLE_WIDTH-1:0] croot_reg, croot_next;
    logic [NUM_W-1:0]        n_reg, n_next;
    logic [DEN_W-1:0]        d_reg, d_next;
    logic                    dark_reg, dark_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_dark_reg, out_dark_next;

    logic                    in_acc;
    logic                    in_kind;
    logic                    in_start;
    logic [SAMPLE_WIDTH-1:0] in_red;
    logic [SAMPLE_WIDTH-1:0] in_green;
    logic [SAMPLE_WIDTH-1:0] in_blue;
    logic [SAMPLE_WIDTH-1:0] peak_max;
    logic                    is_dark;
    logic                    out_load;
    logic                    cfg_write;
    logic [SAMPLE_WIDTH-1:0] root_val;
    logic [NUM_W-1:0]        n_calc;
    logic [DEN_W-1:0]        d_calc;
    unit_cmd_t               cmd;
    unit_rsp_t               rsp;

    // Payload fields.
    assign in_kind  = s_axis_tuser[0];
    assign in_start = s_axis_tuser[1];
    assign in_red   = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_green = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign in_blue  = s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // Running peak, restarted on a frame start.
    always_comb
    begin
        peak_max = in_start ? '0 : peak_value_reg;
        if (in_red > peak_max)
        begin
            peak_max = in_red;
        end
        if (in_green > peak_max)
        begin
            peak_max = in_green;
        end
        if (in_blue > peak_max)
        begin
            peak_max = in_blue;
        end
    end

    assign is_dark  = (peak_value_reg < thr_reg);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign root_val = rsp.value[SAMPLE_WIDTH-1:0];

    // Rounded dividend and divisor for the current channel.
    assign n_calc = NUM_W'(croot_reg) * NUM_W'(SCALE_NUM2)
                  + NUM_W'(peak_root_reg) * NUM_W'(SCALE_HALF_DEN);
    assign d_calc = DEN_W'(peak_root_reg) * DEN_W'(SCALE_DEN2);

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_DARK_THRESHOLD);
    assign thr_next  = cfg_write ? pwdata[SAMPLE_WIDTH-1:0] : thr_reg;
    assign prdata    = (paddr == ADDR_DARK_THRESHOLD) ? 32'(thr_reg) : 32'd0;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_kind == KIND_CONVERT))
                begin
                    if (is_dark)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (!root_ready_reg)
                    begin
                        state_next = ST_ROOT_P;
                    end
                    else
                    begin
                        state_next = ST_ROOT_C;
                    end
                end
            end
            ST_ROOT_P:
            begin
                state_next = ST_WAIT_P;
            end
            ST_WAIT_P:
            begin
                if (rsp.done)
                begin
                    state_next = ST_ROOT_C;
                end
            end
            ST_ROOT_C:
            begin
                state_next = ST_WAIT_C;
            end
            ST_WAIT_C:
            begin
                if (rsp.done)
                begin
                    state_next = (peak_root_reg == '0) ? ST_NEXT : ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_WAIT_D;
            end
            ST_WAIT_D:
            begin
                if (rsp.done)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = (ch_reg == 2'd2) ? ST_OUT : ST_ROOT_C;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and unit commands.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cmd.start     = 1'b0;
        cmd.op        = OP_ROOT;
        cmd.num       = '0;
        cmd.den       = '0;
        unique case (state_reg)
            ST_ROOT_P:
            begin
                cmd.start = 1'b1;
                cmd.num   = NUM_W'(peak_value_reg);
            end
            ST_ROOT_C:
            begin
                cmd.start = 1'b1;
                cmd.num   = NUM_W'(samp_reg[ch_reg]);
            end
            ST_DIV:
            begin
                cmd.start = 1'b1;
                cmd.op    = OP_DIV;
                cmd.num   = n_reg;
                cmd.den   = d_reg;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        peak_value_next = peak_value_reg;
        peak_root_next  = peak_root_reg;
        root_ready_next = root_ready_reg;
        samp_next       = samp_reg;
        q_next          = q_reg;
        ch_next         = ch_reg;
        croot_next      = croot_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        dark_next       = dark_reg;
        out_data_next   = out_data_reg;
        out_dark_next   = out_dark_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_kind == KIND_MEASURE)
                    begin
                        peak_value_next = peak_max;
                        root_ready_next = 1'b0;
                    end
                    else
                    begin
                        samp_next[0] = in_red;
                        samp_next[1] = in_green;
                        samp_next[2] = in_blue;
                        ch_next      = 2'd0;
                        dark_next    = is_dark;
                    end
                end
            end
            ST_WAIT_P:
            begin
                if (rsp.done)
                begin
                    peak_root_next  = root_val;
                    root_ready_next = 1'b1;
                end
            end
            ST_WAIT_C:
            begin
                if (rsp.done)
                begin
                    croot_next = root_val;
                    // Zero peak: no division, any light saturates.
                    q_next[ch_reg] = (root_val != '0) ? OUT_MAX : 8'd0;
                end
            end
            ST_SCALE:
            begin
                n_next = n_calc;
                d_next = d_calc;
            end
            ST_WAIT_D:
            begin
                if (rsp.done)
                begin
                    q_next[ch_reg] = rsp.value[8] ? OUT_MAX : rsp.value[7:0];
                end
            end
            ST_NEXT:
            begin
                if (ch_reg != 2'd2)
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_dark_next  = dark_reg;
                    out_data_next  = dark_reg ? '0 : {q_reg[2], q_reg[1], q_reg[0]};
                end
            end
            default:
            begin
                ch_next = ch_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= SAMPLE_WIDTH'(1);
            peak_value_reg <= '0;
            peak_root_reg  <= '0;
            root_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            peak_value_reg <= peak_value_next;
            peak_root_reg  <= peak_root_next;
            root_ready_reg <= root_ready_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        samp_reg     <= samp_next;
        q_reg        <= q_next;
        ch_reg       <= ch_next;
        croot_reg    <= croot_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        dark_reg     <= dark_next;
        out_data_reg <= out_data_next;
        out_dark_reg <= out_dark_next;
    end

    // Shared root and divide unit.
    mnsq_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_dark_reg;

endmodule

// ===== rtl/core/mnsq_checker.sv =====
`include "max_normalized_sqrt_quantizer_macros.svh"

module mnsq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result transaction keeps its payload.
    `MNSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // A too-dark result carries zero colors.
    `MNSQ_ASSERT_SAME(a_dark_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 24'd0, "too-dark result with nonzero colors")

    // A convert transaction occupies the block in the next cycle.
    `MNSQ_ASSERT_NEXT(a_convert_busy, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready, "ready after convert transaction")

    // A measure transaction leaves the block ready.
    `MNSQ_ASSERT_NEXT(a_measure_ready, clk, rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0], s_axis_tready, "not ready after measure transaction")

endmodule

bind max_normalized_sqrt_quantizer mnsq_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
